FILE: sv/ctsb_pkg.sv
`default_nettype none

package ctsb_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;

   // triangle shape: 15 rows, spans 2..16 then 14..2
   localparam int TRI_ROWS  = 15;
   localparam int HALF_ROWS = 8;
   localparam int MAX_SPAN  = 16;

   localparam int ROW_W  = 4;
   localparam int COL_W  = 4;
   localparam int SPAN_W = 5;

   localparam int ORG_W   = 16;
   localparam int COLOR_W = 8;
   localparam int FUNC_W  = 2;
   localparam int ADDR_W  = 17;

   // origin plus or minus one span always fits these signed widths
   localparam int X_W = ORG_W + 2;
   localparam int Y_W = ORG_W + 1;

   localparam int XL_W = $clog2(SCREEN_WIDTH);
   localparam int YL_W = $clog2(SCREEN_HEIGHT);
   localparam int PROD_W = YL_W + $clog2(SCREEN_WIDTH + 1) + 1;
   localparam int CALC_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

   // colour functions
   localparam logic [FUNC_W-1:0] FUNC_TEXTURED = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SKY      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_KEYED    = 2'd2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_SKY_COLOR_SEL = 1'b0;

   typedef logic [COLOR_W-1:0] color_type;

   function automatic logic [SPAN_W-1:0] row_span(input logic [ROW_W-1:0] r);
      logic [SPAN_W-1:0] rr;
      rr = SPAN_W'(r);
      if (r < ROW_W'(HALF_ROWS)) begin
         row_span = SPAN_W'(2) * (rr + SPAN_W'(1));
      end else begin
         row_span = SPAN_W'(2 * MAX_SPAN - 2) - SPAN_W'(2) * rr;
      end
   endfunction

endpackage

`default_nettype wire

FILE: sv/ctsb_channels.sv
`default_nettype none

interface ctsb_req_if;
   import ctsb_pkg::*;

   logic               valid;
   logic               ready;
   logic               start_req;
   logic [ORG_W-1:0]   anchor_x;
   logic [ORG_W-1:0]   origin_y;
   logic               facing;
   logic [FUNC_W-1:0]  func;
   logic [COLOR_W-1:0] texel;
   logic [COLOR_W-1:0] shadow_bits;
   logic [COLOR_W-1:0] water_bits;
   logic [COLOR_W-1:0] flag_bits;

   modport source (
      output valid, start_req, anchor_x, origin_y, facing, func,
             texel, shadow_bits, water_bits, flag_bits,
      input  ready
   );
   modport sink (
      input  valid, start_req, anchor_x, origin_y, facing, func,
             texel, shadow_bits, water_bits, flag_bits,
      output ready
   );
endinterface

interface ctsb_rsp_if;
   import ctsb_pkg::*;

   logic               valid;
   logic               ready;
   logic               write_enable;
   logic [ADDR_W-1:0]  pixel_address;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_of_triangle;

   modport source (
      output valid, write_enable, pixel_address, pixel_color, last_of_triangle,
      input  ready
   );
   modport sink (
      input  valid, write_enable, pixel_address, pixel_color, last_of_triangle,
      output ready
   );
endinterface

`default_nettype wire

FILE: sv/clipped_triangle_sprite_blit.sv
// clipped triangle sprite blitter
// req_chan carries one texel per transfer. a transfer with start_req set
// latches anchor_x, origin_y and facing and restarts at the top row; other
// texels continue the current triangle (15 rows, 128 texels) and wrap to the
// top row after the last one.
// rsp_chan returns one frame-buffer write per texel: write_enable is low for
// pixels off the screen, for transparent texels in keyed mode and for the
// unused func code, and then address and colour read as zero.
// last_of_triangle marks the 128th texel.
// a taken texel passes through the stage 1 register and then the result
// register. throughput: one texel per clock while rsp_chan takes results;
// the position counters step on acceptance; the address multiply is in stage 2.
// when rsp_chan stalls the result register holds and the two stages fill,
// after which req_chan.ready drops until a result is taken.
// sky_color is written through the apb port at byte address 0; the user
// must do so only while the block is idle; the block does not enforce this.
// reset clears the pipeline, position, held origin and sky_color.
`default_nettype none

module clipped_triangle_sprite_blit (
   input  wire                              clock,
   input  wire                              reset,
   ctsb_req_if.sink                         req_chan,
   ctsb_rsp_if.source                       rsp_chan,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [ctsb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire  [ctsb_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ctsb_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import ctsb_pkg::*;

   // configuration
   color_type sky_color_ff;

   // position and held triangle state
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ORG_W-1:0] org_x_ff, org_x_in;
   logic [ORG_W-1:0] org_y_ff, org_y_in;
   logic             facing_ff, facing_in;

   // stage 1
   logic                  s1_valid_ff;
   logic signed [X_W-1:0] s1_x_ff, s1_x_in;
   logic signed [Y_W-1:0] s1_y_ff, s1_y_in;
   color_type             s1_color_ff, s1_color_in;
   logic                  s1_opaque_ff, s1_opaque_in;
   logic                  s1_last_ff, s1_last_in;

   // stage 2 / result register
   logic              s2_valid_ff;
   logic              s2_we_ff, s2_we_in;
   logic [ADDR_W-1:0] s2_addr_ff, s2_addr_in;
   color_type         s2_color_ff, s2_color_in;
   logic              s2_last_ff;

   logic req_xfer, s2_load, s1_adv;

   logic [ROW_W-1:0]  r_cur;
   logic [COL_W-1:0]  c_cur;
   logic [SPAN_W-1:0] span;
   logic              col_end;
   logic [X_W-1:0]    x_base, x_off;
   logic              on_screen;
   logic [CALC_W-1:0] addr_full;

   // handshake
   assign s2_load  = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign s1_adv   = !s1_valid_ff || s2_load;
   assign req_chan.ready = s1_adv;
   assign req_xfer = req_chan.valid && s1_adv;

   // apb
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == CSR_SKY_COLOR_SEL) begin
         prdata = CSR_DATA_W'(sky_color_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sky_color_ff <= '0;
      end else if (psel && penable && pwrite && pready &&
                   paddr[CSR_ADDR_W-1] == CSR_SKY_COLOR_SEL) begin
         sky_color_ff <= pwdata[COLOR_W-1:0];
      end
   end

   // position walk and colour for the texel being taken
   always_comb begin
      if (req_chan.start_req) begin
         org_x_in  = req_chan.anchor_x;
         org_y_in  = req_chan.origin_y;
         facing_in = req_chan.facing;
         r_cur     = '0;
         c_cur     = '0;
      end else begin
         org_x_in  = org_x_ff;
         org_y_in  = org_y_ff;
         facing_in = facing_ff;
         r_cur     = (row_ff >= ROW_W'(TRI_ROWS)) ? '0 : row_ff;
         c_cur     = col_ff;
      end
      span = row_span(r_cur);
      if (SPAN_W'(c_cur) >= span) begin
         c_cur = '0;
      end
      col_end = (SPAN_W'(c_cur) + SPAN_W'(1)) >= span;

      if (col_end) begin
         col_in = '0;
         row_in = (r_cur == ROW_W'(TRI_ROWS - 1)) ? '0 : r_cur + ROW_W'(1);
      end else begin
         col_in = c_cur + COL_W'(1);
         row_in = r_cur;
      end
      s1_last_in = (r_cur == ROW_W'(TRI_ROWS - 1)) && col_end;

      x_base = {{(X_W - ORG_W){org_x_in[ORG_W-1]}}, org_x_in};
      x_off  = facing_in ? X_W'(c_cur) : X_W'(c_cur) - X_W'(span);
      s1_x_in = $signed(x_base + x_off);
      s1_y_in = $signed({org_y_in[ORG_W-1], org_y_in} + Y_W'(r_cur));

      s1_opaque_in = 1'b1;
      case (req_chan.func)
         FUNC_TEXTURED: s1_color_in = req_chan.texel | req_chan.shadow_bits |
                                      req_chan.water_bits;
         FUNC_SKY:      s1_color_in = sky_color_ff | req_chan.water_bits;
         FUNC_KEYED: begin
            s1_color_in  = req_chan.texel | req_chan.flag_bits;
            s1_opaque_in = req_chan.texel != '0;
         end
         default: begin
            s1_color_in  = '0;
            s1_opaque_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         org_x_ff    <= '0;
         org_y_ff    <= '0;
         facing_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            row_ff    <= row_in;
            col_ff    <= col_in;
            org_x_ff  <= org_x_in;
            org_y_ff  <= org_y_in;
            facing_ff <= facing_in;
         end
         if (s1_adv) begin
            s1_valid_ff <= req_chan.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_x_ff      <= s1_x_in;
         s1_y_ff      <= s1_y_in;
         s1_color_ff  <= s1_color_in;
         s1_opaque_ff <= s1_opaque_in;
         s1_last_ff   <= s1_last_in;
      end
   end

   // clipping and frame-buffer address
   always_comb begin
      on_screen = (s1_x_ff >= 0) && (s1_x_ff < $signed(X_W'(SCREEN_WIDTH))) &&
                  (s1_y_ff >= 0) && (s1_y_ff < $signed(Y_W'(SCREEN_HEIGHT)));
      addr_full = CALC_W'(s1_y_ff[YL_W-1:0]) * CALC_W'(SCREEN_WIDTH) +
                  CALC_W'(s1_x_ff[XL_W-1:0]);
      s2_we_in  = on_screen && s1_opaque_ff;
      s2_addr_in  = s2_we_in ? addr_full[ADDR_W-1:0] : '0;
      s2_color_in = s2_we_in ? s1_color_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!s2_valid_ff || rsp_chan.ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_we_ff    <= s2_we_in;
         s2_addr_ff  <= s2_addr_in;
         s2_color_ff <= s2_color_in;
         s2_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_chan.valid            = s2_valid_ff;
   assign rsp_chan.write_enable     = s2_we_ff;
   assign rsp_chan.pixel_address    = s2_addr_ff;
   assign rsp_chan.pixel_color      = s2_color_ff;
   assign rsp_chan.last_of_triangle = s2_last_ff;

endmodule

`default_nettype wire

FILE: tb/tb_clipped_triangle_sprite_blit.sv
module tb_clipped_triangle_sprite_blit;
   timeunit 1ns;
   timeprecision 1ps;

   import ctsb_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] SKY_COLOR_ADDR = '0;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic              start_req;
      logic [ORG_W-1:0]  anchor_x;
      logic [ORG_W-1:0]  origin_y;
      logic              facing;
      logic [FUNC_W-1:0] func;
      color_type         texel;
      color_type         shadow_bits;
      color_type         water_bits;
      color_type         flag_bits;
   } texel_item_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] pixel_address;
      color_type         pixel_color;
      logic              last_of_triangle;
   } pixel_write_type;

   typedef enum {RX_STEADY, RX_COIN, RX_THIRD, RX_MOSTLY} rx_pattern_type;

   class blit_scoreboard;
      color_type        sky;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [ORG_W-1:0] apex_x;
      logic [ORG_W-1:0] top_y;
      logic             facing_right;
      pixel_write_type  pending_writes[$];
      int errors, texels, starts, ends_seen, writes_seen, sky_settings;

      function new();
         sky = '0;
         row = '0;
         col = '0;
         apex_x = '0;
         top_y = '0;
         facing_right = 1'b0;
         errors = 0;
         texels = 0;
         starts = 0;
         ends_seen = 0;
         writes_seen = 0;
         sky_settings = 0;
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction

      function void set_sky(color_type value);
         sky = value;
         sky_settings++;
      endfunction

      function pixel_write_type predict_pixel(texel_item_type t);
         pixel_write_type p;
         int  r, c, span, x, y, ox, oy;
         bit  on_screen, opaque;
         if (t.start_req) begin
            apex_x = t.anchor_x;
            top_y = t.origin_y;
            facing_right = t.facing;
            row = '0;
            col = '0;
            starts++;
         end
         r = row;
         c = col;
         if (r >= TRI_ROWS) r = 0;
         span = (r < HALF_ROWS) ? 2 * (r + 1) : 2 * MAX_SPAN - 2 - 2 * r;
         if (c >= span) c = 0;
         ox = $signed(apex_x);
         oy = $signed(top_y);
         x = facing_right ? ox + c : ox - span + c;
         y = oy + r;
         on_screen = x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
         opaque = 1'b1;
         p = '0;
         case (t.func)
            FUNC_TEXTURED: p.pixel_color = t.texel | t.shadow_bits | t.water_bits;
            FUNC_SKY:      p.pixel_color = sky | t.water_bits;
            FUNC_KEYED: begin
               opaque = t.texel != '0;
               p.pixel_color = t.texel | t.flag_bits;
            end
            default:       opaque = 1'b0;
         endcase
         p.write_enable = on_screen && opaque;
         if (p.write_enable) p.pixel_address = ADDR_W'(y * SCREEN_WIDTH + x);
         else p.pixel_color = '0;
         p.last_of_triangle = (r == TRI_ROWS - 1) && (c + 1 >= span);
         if (c + 1 >= span) begin
            col = '0;
            row = (r + 1 >= TRI_ROWS) ? '0 : ROW_W'(r + 1);
         end else begin
            col = COL_W'(c + 1);
            row = ROW_W'(r);
         end
         return p;
      endfunction

      function void note_texel(texel_item_type t);
         pending_writes.push_back(predict_pixel(t));
         texels++;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_pixel(pixel_write_type got);
         pixel_write_type want;
         if (got.write_enable) writes_seen++;
         if (got.last_of_triangle) ends_seen++;
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel write %h", got));
         end else begin
            want = pending_writes.pop_front();
            if (got.write_enable !== want.write_enable)
               report_mismatch($sformatf("write_enable %b, want %b",
                                         got.write_enable, want.write_enable));
            if (got.pixel_address !== want.pixel_address)
               report_mismatch($sformatf("pixel_address %0d, want %0d",
                                         got.pixel_address, want.pixel_address));
            if (got.pixel_color !== want.pixel_color)
               report_mismatch($sformatf("pixel_color %h, want %h",
                                         got.pixel_color, want.pixel_color));
            if (got.last_of_triangle !== want.last_of_triangle)
               report_mismatch($sformatf("last_of_triangle %b, want %b",
                                         got.last_of_triangle, want.last_of_triangle));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   ctsb_req_if req_bus ();
   ctsb_rsp_if rsp_bus ();

   clipped_triangle_sprite_blit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   blit_scoreboard sb = new();

   int sent = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   int hold_requests = 0;

   always #10 clock = ~clock;

   // transfers seen at the rising edge
   always @(posedge clock) begin : req_monitor
      texel_item_type seen;
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         seen.start_req   = req_bus.start_req;
         seen.anchor_x    = req_bus.anchor_x;
         seen.origin_y    = req_bus.origin_y;
         seen.facing      = req_bus.facing;
         seen.func        = req_bus.func;
         seen.texel       = req_bus.texel;
         seen.shadow_bits = req_bus.shadow_bits;
         seen.water_bits  = req_bus.water_bits;
         seen.flag_bits   = req_bus.flag_bits;
         sb.note_texel(seen);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      pixel_write_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.write_enable     = rsp_bus.write_enable;
         got.pixel_address    = rsp_bus.pixel_address;
         got.pixel_color      = rsp_bus.pixel_color;
         got.last_of_triangle = rsp_bus.last_of_triangle;
         sb.check_pixel(got);
      end
   end

   // receiver: changing stall patterns, plus long hold-offs on request
   initial begin : receiver
      rx_pattern_type pattern;
      int pattern_left, hold_left, holds_served;
      pattern = RX_STEADY;
      pattern_left = 0;
      hold_left = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern = rx_pattern_type'($urandom_range(0, 3));
               pattern_left = $urandom_range(20, 150);
            end
            pattern_left--;
            case (pattern)
               RX_STEADY: rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_THIRD:  rsp_bus.ready <= (pattern_left % 3 == 0);
               default:   rsp_bus.ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("tb_clipped_triangle_sprite_blit failed");
      $finish;
   end

   function automatic texel_item_type texel_at(bit start, int ox, int oy, bit face,
                                               logic [FUNC_W-1:0] fn, color_type tx,
                                               color_type sh, color_type wa,
                                               color_type fl);
      texel_item_type t;
      t.start_req   = start;
      t.anchor_x    = ORG_W'(ox);
      t.origin_y    = ORG_W'(oy);
      t.facing      = face;
      t.func        = fn;
      t.texel       = tx;
      t.shadow_bits = sh;
      t.water_bits  = wa;
      t.flag_bits   = fl;
      return t;
   endfunction

   function automatic texel_item_type random_texel();
      texel_item_type t;
      t.start_req   = 1'b0;
      t.anchor_x    = ORG_W'($urandom);
      t.origin_y    = ORG_W'($urandom);
      t.facing      = 1'($urandom);
      t.func        = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED
                                                  : FUNC_W'($urandom_range(0, 2));
      t.texel       = ($urandom_range(0, 5) == 0) ? '0 : COLOR_W'($urandom);
      t.shadow_bits = COLOR_W'($urandom);
      t.water_bits  = COLOR_W'($urandom);
      t.flag_bits   = COLOR_W'($urandom);
      return t;
   endfunction

   task automatic push_texel(texel_item_type t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if (gaps_on) begin
            gap = $urandom_range(0, 8);
            repeat (gap) begin
               @(negedge clock);
               req_bus.valid <= 1'b0;
            end
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.start_req   <= t.start_req;
      req_bus.anchor_x    <= t.anchor_x;
      req_bus.origin_y    <= t.origin_y;
      req_bus.facing      <= t.facing;
      req_bus.func        <= t.func;
      req_bus.texel       <= t.texel;
      req_bus.shadow_bits <= t.shadow_bits;
      req_bus.water_bits  <= t.water_bits;
      req_bus.flag_bits   <= t.flag_bits;
      req_bus.valid       <= 1'b1;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sent++;
   endtask

   // sender stops and waits for every outstanding pixel write
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_sky(color_type value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SKY_COLOR_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      sb.set_sky(value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (prdata !== CSR_DATA_W'(value))
         sb.report_mismatch($sformatf("sky_color reads %h, want %h", prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_triangle(int room);
      texel_item_type t;
      int length, ox, oy;
      ox = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 360) - 20 : int'($urandom);
      oy = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 270) - 15 : int'($urandom);
      // mostly a whole triangle or more, often running past the end, some cut short
      length = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 127)
                                           : 128 + $urandom_range(0, 20);
      if (length > room) length = room;
      t = random_texel();
      t.start_req = 1'b1;
      t.anchor_x = ORG_W'(ox);
      t.origin_y = ORG_W'(oy);
      push_texel(t);
      repeat (length - 1) push_texel(random_texel());
   endtask

   task automatic send_noise(int room);
      texel_item_type t;
      int length;
      length = $urandom_range(1, 30);
      if (length > room) length = room;
      repeat (length) begin
         t = random_texel();
         t.start_req = ($urandom_range(0, 5) == 0);
         push_texel(t);
      end
   endtask

   task automatic run_random_phase(int quota);
      int goal;
      goal = sent + quota;
      while (sent < goal) begin
         if ($urandom_range(0, 3) != 0) send_triangle(goal - sent);
         else send_noise(goal - sent);
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.start_req = 1'b0;
      req_bus.anchor_x = '0;
      req_bus.origin_y = '0;
      req_bus.facing = 1'b0;
      req_bus.func = FUNC_TEXTURED;
      req_bus.texel = '0;
      req_bus.shadow_bits = '0;
      req_bus.water_bits = '0;
      req_bus.flag_bits = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // texels straight after reset continue the held origin
      push_texel(texel_at(0, 0, 0, 0, FUNC_TEXTURED, 8'h01, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff));
      push_texel(texel_at(1, 0, 0, 1, FUNC_TEXTURED, 8'h80, 8'h01, 8'h02, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_SKY, 8'h00, 8'h00, 8'h0f, 8'h00));
      // transparent texel, then an opaque one
      push_texel(texel_at(0, 0, 0, 0, FUNC_KEYED, 8'h00, 8'h00, 8'h00, 8'hff));
      push_texel(texel_at(0, 0, 0, 0, FUNC_KEYED, 8'hff, 8'h00, 8'h00, 8'h00));
      // bottom right corner, then just off the right edge
      push_texel(texel_at(1, 319, 239, 1, FUNC_TEXTURED, 8'hff, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_TEXTURED, 8'h11, 8'h22, 8'h44, 8'h00));
      push_texel(texel_at(1, 320, 0, 0, FUNC_KEYED, 8'h55, 8'h00, 8'h00, 8'haa));
      push_texel(texel_at(0, 0, 0, 0, FUNC_KEYED, 8'haa, 8'h00, 8'h00, 8'h55));
      push_texel(texel_at(1, -32768, -32768, 0, FUNC_TEXTURED, 8'hff, 8'hff, 8'hff, 8'hff));
      push_texel(texel_at(1, 32767, 32767, 1, FUNC_SKY, 8'hff, 8'hff, 8'hff, 8'hff));
      // one row above the screen, stepping onto its top row
      push_texel(texel_at(1, 0, -1, 1, FUNC_TEXTURED, 8'h3c, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_TEXTURED, 8'h3c, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_TEXTURED, 8'h3c, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(1, 0, 240, 1, FUNC_TEXTURED, 8'h7e, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(1, 2, 0, 0, FUNC_UNUSED, 8'hff, 8'h00, 8'h00, 8'h00));
      drain();

      write_sky(8'hff);
      push_texel(texel_at(1, 100, 100, 1, FUNC_SKY, 8'h00, 8'h00, 8'h00, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_SKY, 8'h00, 8'h00, 8'h5a, 8'h00));
      push_texel(texel_at(0, 0, 0, 0, FUNC_TEXTURED, 8'h00, 8'h00, 8'h00, 8'h00));
      drain();

      write_sky(COLOR_W'($urandom_range(1, 254)));
      run_random_phase(180);
      drain();

      // receiver holds off while the sender keeps offering
      write_sky(8'h00);
      hold_requests++;
      run_random_phase(180);
      drain();

      // no sender gaps in this stretch
      write_sky(COLOR_W'($urandom));
      gaps_on = 1'b0;
      run_random_phase(180);
      drain();
      repeat (8) @(posedge clock);

      $display("run covered %0d texels, %0d triangle starts, %0d triangle ends,",
               sb.texels, sb.starts, sb.ends_seen);
      $display("%0d enabled pixel writes and %0d sky colour settings",
               sb.writes_seen, sb.sky_settings);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_clipped_triangle_sprite_blit passed");
      end else begin
         $display("tb_clipped_triangle_sprite_blit failed");
      end
      $finish;
   end

endmodule
